### rtl/bsd_pkg.sv
// ----------------------------------------------------------------------------
// bsd_pkg
// Shared codes, widths and reset values for the battery status debouncer.
// ----------------------------------------------------------------------------
package bsd_pkg;

	localparam int unsigned CfgIdxW  = 3;
	localparam int unsigned CfgDataW = 16;

	// register indexes
	localparam logic [CfgIdxW-1:0] CFG_STATUS_PERIOD = 3'd0;
	localparam logic [CfgIdxW-1:0] CFG_FULL_PERIOD   = 3'd1;
	localparam logic [CfgIdxW-1:0] CFG_DEBOUNCE      = 3'd2;
	localparam logic [CfgIdxW-1:0] CFG_TICKS_PER_SEC = 3'd3;
	localparam logic [CfgIdxW-1:0] CFG_DIE_SECONDS   = 3'd4;

	// register reset values
	localparam logic [15:0] RST_STATUS_PERIOD = 16'd100;
	localparam logic [15:0] RST_FULL_PERIOD   = 16'd100;
	localparam logic [7:0]  RST_DEBOUNCE      = 8'd10;
	localparam logic [9:0]  RST_TICKS_PER_SEC = 10'd1000;
	localparam logic [7:0]  RST_DIE_SECONDS   = 8'd105;

	// request codes
	localparam logic [1:0] REQ_TICK = 2'd0;
	localparam logic [1:0] REQ_EVAL = 2'd1;
	localparam logic [1:0] REQ_INIT = 2'd2;

	// battery status codes
	localparam logic [1:0] ST_DIE  = 2'd0;
	localparam logic [1:0] ST_LOW  = 2'd1;
	localparam logic [1:0] ST_NOR  = 2'd2;
	localparam logic [1:0] ST_FULL = 2'd3;

	typedef struct packed {
		logic [1:0] battery_status;
		logic       voltage_low;
		logic       battery_full;
		logic       shutdown_pending;
	} result_t;

	function automatic logic [7:0] inc_sat8(input logic [7:0] v);
		return (v == 8'hFF) ? v : v + 8'd1;
	endfunction

endpackage

### rtl/battery_status_debouncer_unit.sv
// ----------------------------------------------------------------------------
// battery_status_debouncer_unit
// Debounces a low-voltage comparator bit and a charger-full pin into a
// battery state, with a low-battery shutdown timer.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one request per transfer:
//   a tick, an evaluate of the current samples, or a power-up init.
//   Every request produces exactly one result transfer on the output
//   channel (out_valid/out_ready) showing the state after that request.
//   Configuration writes (cfg_valid/cfg_ready, cfg_index, cfg_data) are
//   always taken; indexes past the register list are ignored. Write them
//   only while no request is in flight.
// Latency and throughput:
//   The state update is one pass of logic on the accepted request; the
//   result is registered into the output queue and shown once it reaches
//   the head. One request per cycle is sustained while in_ready is high.
// Reset:
//   arst_n clears all counters, flags and the state (die) and loads the
//   register defaults; the output queue is empty.
// Stall:
//   A two-entry result queue sits on the output. With the receiver
//   stalled the block still takes one more request; in_ready drops only
//   when both entries hold results.
// ----------------------------------------------------------------------------
module battery_status_debouncer_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration write channel
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [bsd_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [bsd_pkg::CfgDataW-1:0]  cfg_data,
	// request channel
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    req_type,
	input  logic                          lvd_below,
	input  logic                          charge_full_pin,
	input  logic                          charging,
	input  logic                          power_off,
	// result channel
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [1:0]                    battery_status,
	output logic                          voltage_low,
	output logic                          battery_full,
	output logic                          shutdown_pending
);
	import bsd_pkg::*;

	// configuration registers
	logic [15:0] status_period_q, full_period_q;
	logic [7:0]  debounce_limit_q, die_seconds_q;
	logic [9:0]  ticks_per_second_q;

	// battery state
	logic [1:0]  status_q;
	logic [15:0] status_tick_q, full_tick_q;
	logic [7:0]  full_cnt_status_q, low_cnt_status_q, normal_cnt_status_q;
	logic        lvd_low_q;
	logic [7:0]  lvd_below_cnt_q, lvd_above_cnt_q;
	logic [9:0]  die_tick_q;
	logic [7:0]  die_second_q;
	logic        die_done_q;
	logic [7:0]  full_on_cnt_q, full_off_cnt_q;
	logic        full_flag_q;

	// next-state values
	logic [1:0]  status_d;
	logic [15:0] status_tick_d, full_tick_d;
	logic [7:0]  full_cnt_status_d, low_cnt_status_d, normal_cnt_status_d;
	logic        lvd_low_d;
	logic [7:0]  lvd_below_cnt_d, lvd_above_cnt_d;
	logic [9:0]  die_tick_d;
	logic [7:0]  die_second_d;
	logic        die_done_d;
	logic [7:0]  full_on_cnt_d, full_off_cnt_d;
	logic        full_flag_d;

	// output queue: head is shown on the ports, tail is the skid entry
	result_t head_q, tail_q, result_d;
	logic    head_valid_q, tail_valid_q;

	logic push, pop;

	assign cfg_ready = 1'b1;
	assign in_ready  = !tail_valid_q;
	assign push      = in_valid && in_ready;
	assign pop       = head_valid_q && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_period_q    <= RST_STATUS_PERIOD;
			full_period_q      <= RST_FULL_PERIOD;
			debounce_limit_q   <= RST_DEBOUNCE;
			ticks_per_second_q <= RST_TICKS_PER_SEC;
			die_seconds_q      <= RST_DIE_SECONDS;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_STATUS_PERIOD: status_period_q    <= cfg_data;
				CFG_FULL_PERIOD:   full_period_q      <= cfg_data;
				CFG_DEBOUNCE:      debounce_limit_q   <= cfg_data[7:0];
				CFG_TICKS_PER_SEC: ticks_per_second_q <= cfg_data[9:0];
				CFG_DIE_SECONDS:   die_seconds_q      <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// one pass of request logic
	always_comb begin
		logic sample;

		status_d            = status_q;
		status_tick_d       = status_tick_q;
		full_tick_d         = full_tick_q;
		full_cnt_status_d   = full_cnt_status_q;
		low_cnt_status_d    = low_cnt_status_q;
		normal_cnt_status_d = normal_cnt_status_q;
		lvd_low_d           = lvd_low_q;
		lvd_below_cnt_d     = lvd_below_cnt_q;
		lvd_above_cnt_d     = lvd_above_cnt_q;
		die_tick_d          = die_tick_q;
		die_second_d        = die_second_q;
		die_done_d          = die_done_q;
		full_on_cnt_d       = full_on_cnt_q;
		full_off_cnt_d      = full_off_cnt_q;
		full_flag_d         = full_flag_q;
		sample              = charge_full_pin && charging;

		case (req_type)
			REQ_TICK: begin
				// shutdown timer runs only in the low state
				if (status_q == ST_LOW) begin
					if (die_tick_q < ticks_per_second_q) begin
						die_tick_d = die_tick_q + 10'd1;
					end else begin
						die_tick_d = '0;
						if (die_second_q < die_seconds_q) begin
							die_second_d = die_second_q + 8'd1;
						end else begin
							die_second_d = '0;
							die_done_d   = 1'b1;
						end
					end
				end
				if (status_tick_q < status_period_q)
					status_tick_d = status_tick_q + 16'd1;
				if (full_tick_q < full_period_q)
					full_tick_d = full_tick_q + 16'd1;
			end
			REQ_EVAL: begin
				// charger full pin, only once its period has elapsed
				if (full_tick_q >= full_period_q) begin
					full_tick_d = '0;
					if (sample) begin
						full_off_cnt_d = '0;
						full_on_cnt_d  = inc_sat8(full_on_cnt_q);
						if (full_on_cnt_d > debounce_limit_q) begin
							full_on_cnt_d = '0;
							full_flag_d   = 1'b1;
						end
					end else begin
						full_on_cnt_d  = '0;
						full_off_cnt_d = inc_sat8(full_off_cnt_q);
						if (full_off_cnt_d > debounce_limit_q) begin
							full_off_cnt_d = '0;
							full_flag_d    = 1'b0;
						end
					end
				end

				// comparator is ignored while full
				if (!full_flag_d) begin
					if (lvd_below) begin
						lvd_above_cnt_d = '0;
						lvd_below_cnt_d = inc_sat8(lvd_below_cnt_q);
						if (lvd_below_cnt_d > debounce_limit_q) begin
							lvd_below_cnt_d = '0;
							lvd_low_d       = 1'b1;
						end
					end else begin
						lvd_below_cnt_d = '0;
						lvd_above_cnt_d = inc_sat8(lvd_above_cnt_q);
						if (lvd_above_cnt_d > debounce_limit_q) begin
							lvd_above_cnt_d = '0;
							lvd_low_d       = 1'b0;
						end
					end
				end else begin
					lvd_below_cnt_d = '0;
					lvd_above_cnt_d = '0;
				end

				// status judge
				if (power_off) begin
					die_tick_d   = '0;
					die_second_d = '0;
					die_done_d   = 1'b0;
				end
				if (status_tick_q >= status_period_q) begin
					status_tick_d = '0;
					if (full_flag_d) begin
						low_cnt_status_d    = '0;
						normal_cnt_status_d = '0;
						full_cnt_status_d   = inc_sat8(full_cnt_status_q);
						if (full_cnt_status_d > debounce_limit_q) begin
							full_cnt_status_d = '0;
							status_d          = ST_FULL;
						end
						die_tick_d   = '0;
						die_second_d = '0;
						die_done_d   = 1'b0;
					end else if (lvd_low_d) begin
						full_cnt_status_d   = '0;
						normal_cnt_status_d = '0;
						low_cnt_status_d    = inc_sat8(low_cnt_status_q);
						if (low_cnt_status_d > debounce_limit_q) begin
							low_cnt_status_d = '0;
							status_d         = ST_LOW;
						end
						// elapsed shutdown timer overrides the low state
						if (die_done_d)
							status_d = ST_DIE;
					end else begin
						full_cnt_status_d   = '0;
						low_cnt_status_d    = '0;
						normal_cnt_status_d = inc_sat8(normal_cnt_status_q);
						if (normal_cnt_status_d > debounce_limit_q) begin
							normal_cnt_status_d = '0;
							status_d            = ST_NOR;
							die_tick_d          = '0;
							die_second_d        = '0;
							die_done_d          = 1'b0;
						end
					end
				end
			end
			REQ_INIT: begin
				status_d = lvd_below ? ST_DIE : ST_NOR;
			end
			default: ;
		endcase

		result_d.battery_status   = status_d;
		result_d.voltage_low      = lvd_low_d;
		result_d.battery_full     = full_flag_d;
		result_d.shutdown_pending = die_done_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_q            <= ST_DIE;
			status_tick_q       <= '0;
			full_tick_q         <= '0;
			full_cnt_status_q   <= '0;
			low_cnt_status_q    <= '0;
			normal_cnt_status_q <= '0;
			lvd_low_q           <= 1'b0;
			lvd_below_cnt_q     <= '0;
			lvd_above_cnt_q     <= '0;
			die_tick_q          <= '0;
			die_second_q        <= '0;
			die_done_q          <= 1'b0;
			full_on_cnt_q       <= '0;
			full_off_cnt_q      <= '0;
			full_flag_q         <= 1'b0;
		end else if (push) begin
			status_q            <= status_d;
			status_tick_q       <= status_tick_d;
			full_tick_q         <= full_tick_d;
			full_cnt_status_q   <= full_cnt_status_d;
			low_cnt_status_q    <= low_cnt_status_d;
			normal_cnt_status_q <= normal_cnt_status_d;
			lvd_low_q           <= lvd_low_d;
			lvd_below_cnt_q     <= lvd_below_cnt_d;
			lvd_above_cnt_q     <= lvd_above_cnt_d;
			die_tick_q          <= die_tick_d;
			die_second_q        <= die_second_d;
			die_done_q          <= die_done_d;
			full_on_cnt_q       <= full_on_cnt_d;
			full_off_cnt_q      <= full_off_cnt_d;
			full_flag_q         <= full_flag_d;
		end
	end

	// two-entry result queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_valid_q <= 1'b0;
			tail_valid_q <= 1'b0;
		end else if (pop) begin
			if (tail_valid_q) begin
				tail_valid_q <= 1'b0;
			end else begin
				head_valid_q <= push;
			end
		end else if (push) begin
			if (!head_valid_q) begin
				head_valid_q <= 1'b1;
			end else begin
				tail_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (tail_valid_q) begin
				head_q <= tail_q;
			end else if (push) begin
				head_q <= result_d;
			end
		end else if (push) begin
			if (!head_valid_q) begin
				head_q <= result_d;
			end else begin
				tail_q <= result_d;
			end
		end
	end

	assign out_valid        = head_valid_q;
	assign battery_status   = head_q.battery_status;
	assign voltage_low      = head_q.voltage_low;
	assign battery_full     = head_q.battery_full;
	assign shutdown_pending = head_q.shutdown_pending;

endmodule
